[design/strict_priority_multi_queue_assert.svh]
// Assertion macros for the strict priority multi-queue.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define SPMQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spmq assertion failed");

`define SPMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spmq assertion failed");

`else

`define SPMQ_ASSERT_IMPL(label, clk, rst, ante, cons)

`define SPMQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/spmq_pkg.sv]
// Shared types and constants of the strict priority multi-queue.
`default_nettype none

package spmq_pkg;

   localparam int NUM_LEVELS  = 4;
   localparam int QUEUE_DEPTH = 16;

   localparam int QIDX_W    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W     = PTR_W + 1;
   localparam int ADDR_W    = QIDX_W + PTR_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;

   localparam logic [3:0]       LEVEL_LAST = 4'(NUM_LEVELS);
   localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [SUM_W-1:0] SUM_DEPTH  = SUM_W'(QUEUE_DEPTH);

   localparam logic [7:0] OP_IDLE = 8'h49;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_PEEK   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_LEVEL = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  level;
      logic [29:0] id_primary;
      logic [9:0]  id_secondary;
      logic [7:0]  op_code;
      logic [55:0] desc_chars_0;
      logic [55:0] desc_chars_1;
      logic [55:0] desc_chars_2;
      logic [55:0] desc_chars_3;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  head_level;
      logic [29:0] head_id_primary;
      logic [9:0]  head_id_secondary;
      logic [7:0]  head_op_code;
      logic [55:0] head_desc_0;
      logic [55:0] head_desc_1;
      logic [55:0] head_desc_2;
      logic [55:0] head_desc_3;
      logic        all_empty;
   } rsp_payload_type;

   typedef struct packed {
      logic [29:0] id_primary;
      logic [9:0]  id_secondary;
      logic [7:0]  op_code;
      logic [55:0] desc_0;
      logic [55:0] desc_1;
      logic [55:0] desc_2;
      logic [55:0] desc_3;
   } record_type;

   typedef struct packed {
      logic exec;
      logic load;
   } spmq_cmd_type;

endpackage

`default_nettype wire

[design/spmq_req_if.sv]
// Request channel interface carrying one operation item.
`default_nettype none

interface spmq_req_if;
   logic                      valid;
   logic                      ready;
   spmq_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/spmq_rsp_if.sv]
// Response channel interface carrying one result item.
`default_nettype none

interface spmq_rsp_if;
   logic                      valid;
   logic                      ready;
   spmq_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/strict_priority_multi_queue.sv]
// Top level of the strict priority multi-queue of client records.
//
//   Channel   Direction  Handshake              Item
//   req_chan  in         valid/ready            one insert, remove or peek operation
//   rsp_chan  out        valid/ready            one result with status and head record
//
// In the accept cycle an item updates the queue counters and head pointers and
// starts the synchronous record memory read; the load state then fills the output
// register once the output slot is free, so a busy output slot can stall it.
// Reset is synchronous and clears the counters and pointers; the record memory
// needs no clearing pass. A result waiting in the output register does not block
// the next item; a second result waits in the datapath with the input closed.
`default_nettype none

module strict_priority_multi_queue (
   input  logic        clock,
   input  logic        reset,
   spmq_req_if.sink    req_chan,
   spmq_rsp_if.source  rsp_chan
);
   import spmq_pkg::*;

   spmq_cmd_type cmd;

   spmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   spmq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_chan.payload),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

`default_nettype wire

[design/spmq_dp.sv]
// Datapath with queue counters, head pointers, record memory and output register.
`default_nettype none

`include "strict_priority_multi_queue_assert.svh"

module spmq_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  spmq_pkg::spmq_cmd_type    cmd,
   input  spmq_pkg::req_payload_type req_payload,
   output spmq_pkg::rsp_payload_type rsp_payload
);
   import spmq_pkg::*;

   logic [CNT_W-1:0]  count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]  count_in [NUM_LEVELS];
   logic [PTR_W-1:0]  head_ff  [NUM_LEVELS];
   logic [PTR_W-1:0]  head_in  [NUM_LEVELS];

   record_type        store_ff [MEM_DEPTH];
   record_type        rd_data_ff;
   record_type        wr_data;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic              rd_en;

   logic              top_found;
   logic [QIDX_W-1:0] top_q;
   logic [QIDX_W-1:0] ins_q;
   logic              level_ok;
   logic [SUM_W-1:0]  tail_sum;
   logic [PTR_W-1:0]  tail_pos;

   status_type        status_ff, status_in;
   logic              peek_ok_ff, peek_ok_in;
   logic              idle_op_ff, idle_op_in;
   logic              all_empty_ff, all_empty_in;
   logic [3:0]        head_level_ff;
   rsp_payload_type   rsp_ff, rsp_in;

   always_comb begin
      top_found = 1'b0;
      top_q     = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            top_found = 1'b1;
            top_q     = QIDX_W'(i);
         end
      end
   end

   assign level_ok = (req_payload.level != 4'd0) && (req_payload.level <= LEVEL_LAST);
   assign ins_q    = QIDX_W'(req_payload.level - 4'd1);
   assign tail_sum = SUM_W'(head_ff[ins_q]) + SUM_W'(count_ff[ins_q]);
   assign tail_pos = (tail_sum >= SUM_DEPTH) ? PTR_W'(tail_sum - SUM_DEPTH)
                                             : PTR_W'(tail_sum);

   assign wr_addr = {ins_q, tail_pos};
   assign rd_addr = {top_q, head_ff[top_q]};

   assign wr_data.id_primary   = req_payload.id_primary;
   assign wr_data.id_secondary = req_payload.id_secondary;
   assign wr_data.op_code      = req_payload.op_code;
   assign wr_data.desc_0       = req_payload.desc_chars_0;
   assign wr_data.desc_1       = req_payload.desc_chars_1;
   assign wr_data.desc_2       = req_payload.desc_chars_2;
   assign wr_data.desc_3       = req_payload.desc_chars_3;

   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         count_in[i] = count_ff[i];
         head_in[i]  = head_ff[i];
      end
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      status_in  = STATUS_OK;
      peek_ok_in = 1'b0;
      idle_op_in = 1'b0;
      if (cmd.exec) begin
         unique case (req_payload.kind)
            KIND_INSERT: begin
               if (!level_ok) begin
                  status_in = STATUS_BAD_LEVEL;
               end else if (count_ff[ins_q] == CNT_FULL) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en           = 1'b1;
                  count_in[ins_q] = count_ff[ins_q] + CNT_W'(1);
               end
            end
            KIND_REMOVE: begin
               if (!top_found) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in[top_q] = count_ff[top_q] - CNT_W'(1);
                  head_in[top_q]  = (head_ff[top_q] == PTR_LAST) ? '0
                                    : head_ff[top_q] + PTR_W'(1);
               end
            end
            KIND_PEEK: begin
               if (!top_found) begin
                  status_in  = STATUS_EMPTY;
                  idle_op_in = 1'b1;
               end else begin
                  rd_en      = 1'b1;
                  peek_ok_in = 1'b1;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_comb begin
      all_empty_in = 1'b1;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (count_in[i] != '0) begin
            all_empty_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
         status_ff    <= STATUS_OK;
         peek_ok_ff   <= 1'b0;
         idle_op_ff   <= 1'b0;
         all_empty_ff <= 1'b1;
      end else if (cmd.exec) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            count_ff[i] <= count_in[i];
            head_ff[i]  <= head_in[i];
         end
         status_ff    <= status_in;
         peek_ok_ff   <= peek_ok_in;
         idle_op_ff   <= idle_op_in;
         all_empty_ff <= all_empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         head_level_ff <= 4'(top_q) + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_comb begin
      rsp_in                   = '0;
      rsp_in.status            = status_ff;
      rsp_in.all_empty         = all_empty_ff;
      if (peek_ok_ff) begin
         rsp_in.head_level        = head_level_ff;
         rsp_in.head_id_primary   = rd_data_ff.id_primary;
         rsp_in.head_id_secondary = rd_data_ff.id_secondary;
         rsp_in.head_op_code      = rd_data_ff.op_code;
         rsp_in.head_desc_0       = rd_data_ff.desc_0;
         rsp_in.head_desc_1       = rd_data_ff.desc_1;
         rsp_in.head_desc_2       = rd_data_ff.desc_2;
         rsp_in.head_desc_3       = rd_data_ff.desc_3;
      end else if (idle_op_ff) begin
         rsp_in.head_op_code      = OP_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cnt_chk
      `SPMQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff[g] <= CNT_FULL)
   end
   `SPMQ_ASSERT_IMPL(a_peek_excl, clock, reset, peek_ok_ff, !idle_op_ff)
   `SPMQ_ASSERT_IMPL(a_peek_status, clock, reset, peek_ok_ff, status_ff == STATUS_OK)
   `SPMQ_ASSERT_IMPL(a_empty_flag, clock, reset, idle_op_ff, all_empty_ff)

endmodule

`default_nettype wire

[design/spmq_ctrl.sv]
// Controller state machine sequencing item execution and result delivery.
`default_nettype none

`include "strict_priority_multi_queue_assert.svh"

module spmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output spmq_pkg::spmq_cmd_type cmd
);
   import spmq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LOAD = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cmd.exec  = req_valid && req_ready;
   assign cmd.load  = (state_ff == S_LOAD) && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.exec) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SPMQ_ASSERT_NEXT(a_exec_to_load, clock, reset, cmd.exec, state_ff == S_LOAD)
   `SPMQ_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load, rsp_valid_ff)
   `SPMQ_ASSERT_IMPL(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `SPMQ_ASSERT_IMPL(a_no_overlap, clock, reset, cmd.load, !cmd.exec)

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the strict priority multi-queue of client records.
module tb;
   import spmq_pkg::*;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         SLOT_COUNT   = NUM_LEVELS * QUEUE_DEPTH;
   localparam int         RANDOM_ITEMS = 1650;
   localparam int         SETTLE_CYCLES = 20;

   typedef struct {
      bit              hold;
      req_payload_type item;
   } backlog_entry_type;

   logic clock;
   logic reset;

   spmq_req_if req_if ();
   spmq_rsp_if rsp_if ();

   strict_priority_multi_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   backlog_entry_type req_backlog[$];
   rsp_payload_type   awaited_results[$];

   record_type slot_rec[SLOT_COUNT];
   int         head_pos[NUM_LEVELS];
   int         fill_count[NUM_LEVELS];

   int errors = 0;
   int total_items = 0;
   int accepted_count = 0;
   int issued_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_left = 0;
   int rcv_cycle = 0;
   bit next_ready;
   backlog_entry_type next_entry;
   rsp_payload_type   oldest_result;

   always #5 clock = ~clock;

   function automatic rsp_payload_type apply_operation(req_payload_type op);
      rsp_payload_type res;
      record_type      rec;
      int              q;
      int              top;
      int              pos;
      res = '0;
      top = -1;
      for (q = NUM_LEVELS - 1; q >= 0; q--) begin
         if (top < 0 && fill_count[q] != 0) begin
            top = q;
         end
      end
      case (op.kind)
         KIND_INSERT: begin
            if (op.level == 0 || op.level > NUM_LEVELS) begin
               res.status = STATUS_BAD_LEVEL;
            end else begin
               q = op.level - 1;
               if (fill_count[q] >= QUEUE_DEPTH) begin
                  res.status = STATUS_FULL;
               end else begin
                  pos = q * QUEUE_DEPTH + (head_pos[q] + fill_count[q]) % QUEUE_DEPTH;
                  rec.id_primary   = op.id_primary;
                  rec.id_secondary = op.id_secondary;
                  rec.op_code      = op.op_code;
                  rec.desc_0       = op.desc_chars_0;
                  rec.desc_1       = op.desc_chars_1;
                  rec.desc_2       = op.desc_chars_2;
                  rec.desc_3       = op.desc_chars_3;
                  slot_rec[pos] = rec;
                  fill_count[q] = fill_count[q] + 1;
               end
            end
         end
         KIND_REMOVE: begin
            if (top < 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               head_pos[top]   = (head_pos[top] + 1) % QUEUE_DEPTH;
               fill_count[top] = fill_count[top] - 1;
            end
         end
         KIND_PEEK: begin
            if (top < 0) begin
               res.status       = STATUS_EMPTY;
               res.head_op_code = OP_IDLE;
            end else begin
               rec = slot_rec[top * QUEUE_DEPTH + head_pos[top]];
               res.head_level        = 4'(top + 1);
               res.head_id_primary   = rec.id_primary;
               res.head_id_secondary = rec.id_secondary;
               res.head_op_code      = rec.op_code;
               res.head_desc_0       = rec.desc_0;
               res.head_desc_1       = rec.desc_1;
               res.head_desc_2       = rec.desc_2;
               res.head_desc_3       = rec.desc_3;
            end
         end
         default: begin
         end
      endcase
      res.all_empty = 1'b1;
      for (q = 0; q < NUM_LEVELS; q++) begin
         if (fill_count[q] != 0) begin
            res.all_empty = 1'b0;
         end
      end
      return res;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors = errors + 1;
      end
   endtask

   task automatic check_result(rsp_payload_type want, rsp_payload_type got);
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("head_level", 64'(want.head_level), 64'(got.head_level));
      compare_field("head_id_primary", 64'(want.head_id_primary), 64'(got.head_id_primary));
      compare_field("head_id_secondary", 64'(want.head_id_secondary),
                    64'(got.head_id_secondary));
      compare_field("head_op_code", 64'(want.head_op_code), 64'(got.head_op_code));
      compare_field("head_desc_0", 64'(want.head_desc_0), 64'(got.head_desc_0));
      compare_field("head_desc_1", 64'(want.head_desc_1), 64'(got.head_desc_1));
      compare_field("head_desc_2", 64'(want.head_desc_2), 64'(got.head_desc_2));
      compare_field("head_desc_3", 64'(want.head_desc_3), 64'(got.head_desc_3));
      compare_field("all_empty", 64'(want.all_empty), 64'(got.all_empty));
   endtask

   task automatic queue_item(logic [1:0] kind, logic [3:0] level, logic [29:0] prim,
                             logic [9:0] sec, logic [7:0] op, logic [55:0] d0,
                             logic [55:0] d1, logic [55:0] d2, logic [55:0] d3);
      backlog_entry_type e;
      e.hold               = 1'b0;
      e.item.kind          = kind;
      e.item.level         = level;
      e.item.id_primary    = prim;
      e.item.id_secondary  = sec;
      e.item.op_code       = op;
      e.item.desc_chars_0  = d0;
      e.item.desc_chars_1  = d1;
      e.item.desc_chars_2  = d2;
      e.item.desc_chars_3  = d3;
      req_backlog.push_back(e);
      total_items = total_items + 1;
   endtask

   task automatic queue_random(logic [1:0] kind, logic [3:0] level);
      queue_item(kind, level, 30'($urandom_range(0, 999999999)), 10'($urandom_range(0, 999)),
                 8'($urandom_range(0, 255)), 56'({$urandom, $urandom}),
                 56'({$urandom, $urandom}), 56'({$urandom, $urandom}),
                 56'({$urandom, $urandom}));
   endtask

   task automatic queue_hold();
      backlog_entry_type e;
      e.hold = 1'b1;
      e.item = '0;
      req_backlog.push_back(e);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_if.payload);
               errors = errors + 1;
            end else begin
               oldest_result = awaited_results.pop_front();
               check_result(oldest_result, rsp_if.payload);
            end
         end
         if (req_if.valid && req_if.ready) begin
            awaited_results.push_back(apply_operation(req_if.payload));
            accepted_count = accepted_count + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_if.valid || accepted_count == issued_count)) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (req_backlog.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (req_backlog[0].hold) begin
            req_if.valid <= 1'b0;
            if (awaited_results.size() == 0) begin
               void'(req_backlog.pop_front());
            end
         end else begin
            next_entry = req_backlog.pop_front();
            req_if.payload <= next_entry.item;
            req_if.valid <= 1'b1;
            issued_count = issued_count + 1;
            if (burst_left > 1) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   always @(negedge clock) begin
      rcv_cycle = rcv_cycle + 1;
      case ((rcv_cycle / 250) % 4)
         0: begin
            next_ready = 1'b1;
         end
         1: begin
            next_ready = ($urandom_range(0, 3) != 0);
         end
         2: begin
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               next_ready = 1'b0;
            end else begin
               next_ready = 1'b1;
               if ($urandom_range(0, 4) == 0) begin
                  stall_left = $urandom_range(1, 10);
               end
            end
         end
         default: begin
            next_ready = ($urandom_range(0, 9) < 3);
         end
      endcase
      rsp_if.ready <= next_ready;
   end

   initial begin
      int  random_count;
      int  n;
      int  i;
      int  phase;
      int  r;
      int  lvl;
      bit  hold_done;
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      for (i = 0; i < NUM_LEVELS; i++) begin
         head_pos[i]   = 0;
         fill_count[i] = 0;
      end

      queue_random(KIND_PEEK, 4'd0);
      queue_random(KIND_REMOVE, 4'd15);
      queue_random(KIND_UNUSED, 4'd0);
      queue_random(KIND_INSERT, 4'd0);
      queue_random(KIND_INSERT, 4'd15);
      queue_random(KIND_INSERT, 4'(NUM_LEVELS + 1));
      queue_item(KIND_INSERT, 4'd1, 30'd999999999, 10'd999, 8'hFF, {56{1'b1}}, {56{1'b1}},
                 {56{1'b1}}, {56{1'b1}});
      queue_item(KIND_INSERT, 4'd1, '0, '0, '0, '0, '0, '0, '0);
      queue_random(KIND_INSERT, LEVEL_LAST);
      queue_random(KIND_INSERT, 4'd2);
      queue_random(KIND_INSERT, 4'd3);
      queue_random(KIND_PEEK, 4'd0);
      queue_random(KIND_REMOVE, 4'd0);
      queue_random(KIND_PEEK, 4'd9);
      queue_random(KIND_REMOVE, 4'd0);
      queue_random(KIND_REMOVE, 4'd0);
      queue_random(KIND_PEEK, 4'd0);
      queue_random(KIND_UNUSED, 4'd15);
      queue_random(KIND_REMOVE, 4'd0);
      queue_random(KIND_PEEK, 4'd0);
      queue_random(KIND_REMOVE, 4'd0);
      queue_random(KIND_PEEK, 4'd0);
      queue_item(KIND_INSERT, LEVEL_LAST, '0, '0, OP_IDLE, '0, '0, '0, '0);
      queue_random(KIND_REMOVE, 4'd0);

      random_count = 0;
      hold_done = 1'b0;
      while (random_count < RANDOM_ITEMS) begin
         phase = $urandom_range(0, 9);
         if (phase < 3) begin
            lvl = $urandom_range(1, NUM_LEVELS);
            n = $urandom_range(10, 22);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  queue_random(KIND_PEEK, 4'($urandom_range(0, 15)));
               end else begin
                  queue_random(KIND_INSERT, 4'(lvl));
               end
            end
         end else if (phase < 5) begin
            n = $urandom_range(5, 70);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(0, 3) == 0) begin
                  queue_random(KIND_PEEK, 4'($urandom_range(0, 15)));
               end else begin
                  queue_random(KIND_REMOVE, 4'($urandom_range(0, 15)));
               end
            end
         end else begin
            n = $urandom_range(10, 40);
            for (i = 0; i < n; i++) begin
               r = $urandom_range(0, 99);
               if (r < 40) begin
                  queue_random(KIND_INSERT, 4'($urandom_range(1, NUM_LEVELS)));
               end else if (r < 45) begin
                  lvl = $urandom_range(0, 15 - NUM_LEVELS);
                  if (lvl > 0) begin
                     lvl = lvl + NUM_LEVELS;
                  end
                  queue_random(KIND_INSERT, 4'(lvl));
               end else if (r < 70) begin
                  queue_random(KIND_REMOVE, 4'($urandom_range(0, 15)));
               end else if (r < 95) begin
                  queue_random(KIND_PEEK, 4'($urandom_range(0, 15)));
               end else begin
                  queue_random(KIND_UNUSED, 4'($urandom_range(0, 15)));
               end
            end
         end
         random_count = random_count + n;
         if (!hold_done && random_count > RANDOM_ITEMS / 2) begin
            queue_hold();
            hold_done = 1'b1;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("strict_priority_multi_queue regression: pass");
      end else begin
         $display("strict_priority_multi_queue regression: fail");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("strict_priority_multi_queue regression: fail");
      $finish;
   end
endmodule
